// File: hw/rtl/twl_pkg.sv
// shared constants, types and helpers of the table waveshaper
package twl_pkg;

  localparam int unsigned TABLE_DEPTH = 1025;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned LEN_W       = 11;
  localparam int unsigned SHIFT_W     = 4;
  localparam int unsigned EVEN_DEPTH  = (TABLE_DEPTH + 1) / 2;
  localparam int unsigned ODD_DEPTH   = TABLE_DEPTH / 2;
  localparam int unsigned EVEN_AW     = $clog2(EVEN_DEPTH);
  localparam int unsigned ODD_AW      = $clog2(ODD_DEPTH);
  localparam int unsigned PROD_W      = 2 * (SAMPLE_W + 1);

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_WRITE  = 1'b1
  } op_e;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // number of significant bits of v
  function automatic logic [4:0] bit_len(logic [LEN_W-1:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < int'(LEN_W); i++) begin
      if (v[i]) begin
        n = 5'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

// File: hw/rtl/twl_ram.sv
// generic single write port, single read port ram with registered read
module twl_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/table_waveshaper_lerp_top.sv
// table waveshaper: curve lookup with linear interpolation, four-stage pipeline
//
// input channel: in_valid_i / in_stall_o carry one transaction per item. op_i
// selects a sample to shape (sample_in_i) or a curve point write (point_index_i,
// point_value_i). point writes give no result.
// output channel: out_valid_o / out_stall_i carry one sample_out_o per sample.
// configuration: cfg_we_i writes cfg_wdata_i as the curve length; write it only
// while no transaction is in flight. a length below 2 or above the table depth
// passes samples through unchanged.
// path: a sample passes the input register, the address and bank read, the multiply
// and the output register in that order.
// throughput: one transaction per cycle while in_stall_o is low. the two neighbor points
// come from an even and an odd bank of the curve memory, so both reads fit in one cycle.
// when out_stall_i is high the output holds and empty stages still fill; the
// input stalls only once all four stages hold a transaction.
// reset clears the valid bits and the curve length; curve points are undefined
// until written.
module table_waveshaper_lerp_top
  import twl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [LEN_W-1:0]    cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                op_i,
  input  logic signed [15:0]  sample_in_i,
  input  logic [10:0]         point_index_i,
  input  logic signed [15:0]  point_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [15:0]  sample_out_o
);

  // configuration
  logic               pass_q;
  logic [LEN_W-1:0]   lenm1_q, lenm1_d;
  logic [SHIFT_W-1:0] shift_q;

  assign lenm1_d = cfg_wdata_i - LEN_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q  <= 1'b1;
      lenm1_q <= '0;
      shift_q <= '0;
    end else if (cfg_we_i) begin
      pass_q  <= (cfg_wdata_i < LEN_W'(2)) || (32'(cfg_wdata_i) > TABLE_DEPTH);
      lenm1_q <= lenm1_d;
      shift_q <= SHIFT_W'(5'd16 - bit_len(lenm1_d));
    end
  end

  // stage handshake
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4       = !v4_q || !out_stall_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_stall_o = !rdy1;

  // stage 1: input register
  logic               op1_q;
  sample_t            sample1_q;
  logic [10:0]        idx1_q;
  sample_t            value1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      op1_q     <= op_i;
      sample1_q <= sample_in_i;
      idx1_q    <= point_index_i;
      value1_q  <= point_value_i;
    end
  end

  // stage 2: segment address, bank write or read
  logic [SAMPLE_W-1:0] x1, xa1, frac1;
  logic                last1;
  logic [LEN_W-1:0]    a1, a1_half, a1_next;
  logic                is_sample1, is_write1;
  logic                we_even, we_odd, wr_ok;
  logic [EVEN_AW-1:0]  even_raddr;
  logic [ODD_AW-1:0]   odd_raddr;
  logic [SAMPLE_W-1:0] even_rdata, odd_rdata;

  assign is_sample1 = v1_q && (op1_q == OP_SAMPLE);
  assign is_write1  = v1_q && (op1_q == OP_WRITE);
  assign x1         = {~sample1_q[SAMPLE_W-1], sample1_q[SAMPLE_W-2:0]};
  assign xa1        = x1 >> shift_q;
  assign frac1      = x1 & ~({SAMPLE_W{1'b1}} << shift_q);
  assign last1      = xa1 >= SAMPLE_W'(lenm1_q);
  assign a1         = last1 ? lenm1_q : xa1[LEN_W-1:0];
  assign a1_half    = a1 >> 1;
  assign a1_next    = a1_half + LEN_W'(1);
  assign even_raddr = a1[0] ? EVEN_AW'(a1_next) : EVEN_AW'(a1_half);
  assign odd_raddr  = ODD_AW'(a1_half);

  assign wr_ok   = is_write1 && rdy2 && (32'(idx1_q) < TABLE_DEPTH);
  assign we_even = wr_ok && !idx1_q[0];
  assign we_odd  = wr_ok && idx1_q[0];

  twl_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (EVEN_DEPTH)
  ) u_even_ram (
    .clk_i   (clk_i),
    .we_i    (we_even),
    .waddr_i (EVEN_AW'(idx1_q >> 1)),
    .wdata_i (value1_q),
    .re_i    (rdy2 && is_sample1),
    .raddr_i (even_raddr),
    .rdata_o (even_rdata)
  );

  twl_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (ODD_DEPTH)
  ) u_odd_ram (
    .clk_i   (clk_i),
    .we_i    (we_odd),
    .waddr_i (ODD_AW'(idx1_q >> 1)),
    .wdata_i (value1_q),
    .re_i    (rdy2 && is_sample1),
    .raddr_i (odd_raddr),
    .rdata_o (odd_rdata)
  );

  sample_t             sample2_q;
  logic [SAMPLE_W-1:0] frac2_q;
  logic                last2_q, odd2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= is_sample1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && is_sample1) begin
      sample2_q <= sample1_q;
      frac2_q   <= frac1;
      last2_q   <= last1;
      odd2_q    <= a1[0];
    end
  end

  // stage 3: slope times fraction
  sample_t                   ya2, yb2;
  logic signed [SAMPLE_W:0]  delta2, frac2_s;
  logic signed [PROD_W-1:0]  prod2;

  assign ya2     = odd2_q ? odd_rdata : even_rdata;
  assign yb2     = odd2_q ? even_rdata : odd_rdata;
  assign delta2  = {yb2[SAMPLE_W-1], yb2} - {ya2[SAMPLE_W-1], ya2};
  assign frac2_s = {1'b0, frac2_q};
  assign prod2   = delta2 * frac2_s;

  sample_t                  sample3_q, ya3_q;
  logic signed [PROD_W-1:0] prod3_q;
  logic                     last3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      sample3_q <= sample2_q;
      ya3_q     <= ya2;
      prod3_q   <= prod2;
      last3_q   <= last2_q;
    end
  end

  // stage 4: floor shift, add and select into the output register
  logic signed [PROD_W-1:0] step3;
  logic signed [SAMPLE_W:0] sum3;
  sample_t                  result3;
  sample_t                  out_q;

  assign step3 = prod3_q >>> shift_q;
  assign sum3  = {ya3_q[SAMPLE_W-1], ya3_q} + step3[SAMPLE_W:0];

  always_comb begin
    if (pass_q) begin
      result3 = sample3_q;
    end else if (last3_q) begin
      result3 = ya3_q;
    end else begin
      result3 = sum3[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (rdy4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      out_q <= result3;
    end
  end

  assign out_valid_o  = v4_q;
  assign sample_out_o = out_q;

  // checks
  a_no_dual_bank_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we_even && we_odd))
    else $error("both curve banks written in one cycle");

  a_write_gives_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_write1 && rdy2) |=> !v2_q)
    else $error("point write transaction entered the read stage");

  a_sample_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_sample1 && rdy2) |=> v2_q)
    else $error("sample transaction lost after the input stage");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && v4_q))
    else $error("input stalled with a free pipeline stage");

endmodule
